>>> rtl/kdll_pkg.sv
// Shared constants for the keyed doubly linked list.
package kdll_pkg;
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 40;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef logic [STAT_W-1:0] status_t;
endpackage

>>> rtl/keyed_doubly_linked_list.sv
// Keyed doubly linked list: sequencer, key scan unit and node memories.
//
//  channel | dir | fields (low bit up)
//  s_*     | in  | tdata: command[1:0] key[33:2] anchor_key[65:34]
//  m_*     | out | tdata: status[1:0] next_key[33:2] at_end[34]
//
// A key lookup scans the key memory one slot per cycle through one compare
// unit, two scans for an insert with an anchor. Link updates then run through
// the alloc and link states, or remove read and write. One request at a time;
// s_tready is low from accept until the result is loaded in the output
// register. Reset clears valid marks, sentinel links and free counters.
module keyed_doubly_linked_list #(
    parameter int NODES    = 256,
    parameter int KEY_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [kdll_pkg::IN_W-1:0]  s_tdata,  // command, key, anchor_key
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [kdll_pkg::OUT_W-1:0] m_tdata   // status, next_key, at_end
);
    import kdll_pkg::*;

    localparam int SW = $clog2(NODES);
    localparam int LW = $clog2(NODES + 2);
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam logic [LW-1:0] HEAD = LW'(NODES);
    localparam logic [LW-1:0] TAIL = LW'(NODES + 1);
    localparam logic [SW:0]   CNT_FULL = (SW+1)'(NODES);
    localparam logic [SW:0]   LAST = (SW+1)'(NODES - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_ALLOC = 4'd2;
    localparam logic [3:0] S_LINK1 = 4'd3;
    localparam logic [3:0] S_LINK2 = 4'd4;
    localparam logic [3:0] S_RMRD  = 4'd5;
    localparam logic [3:0] S_RMWR  = 4'd6;
    localparam logic [3:0] S_QRD   = 4'd7;
    localparam logic [3:0] S_QNX   = 4'd8;
    localparam logic [3:0] S_QKEY  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [KW-1:0] key_mem  [NODES];
    logic [LW-1:0] next_mem [NODES];
    logic [LW-1:0] prev_mem [NODES];
    logic [SW-1:0] free_mem [NODES];
    logic          vld_reg  [NODES];

    logic [3:0]       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [KW-1:0]    k_reg, k_next, a_reg, a_next;
    logic             anc_phase_reg, anc_phase_next;
    logic [SW:0]      scan_reg, scan_next;
    logic [SW:0]      cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [LW-1:0]    node_reg, node_next;
    logic [LW-1:0]    slot_reg, slot_next;
    logic [LW-1:0]    after_reg, after_next;
    logic [LW-1:0]    head_next_reg, head_next_next;
    logic [LW-1:0]    tail_prev_reg, tail_prev_next;
    logic [SW:0]      rc_reg, rc_next;
    logic [SW:0]      fr_reg, fr_next;
    status_t          res_st_reg, res_st_next;
    logic [KW-1:0]    res_nk_reg, res_nk_next;
    logic             res_end_reg, res_end_next;
    logic             out_vld_reg;
    status_t          out_st_reg;
    logic [KW-1:0]    out_nk_reg;
    logic             out_end_reg;

    logic [KW-1:0] key_rd_reg;
    logic          vld_rd_reg;
    logic [LW-1:0] next_rd_reg, prev_rd_reg;
    logic [SW-1:0] free_rd_reg;

    logic [SW-1:0] key_raddr;
    logic          key_we;
    logic [SW-1:0] key_waddr;
    logic          vld_we, vld_wdata;
    logic          next_we, prev_we;
    logic [SW-1:0] next_waddr, prev_waddr;
    logic [LW-1:0] next_wdata, prev_wdata;
    logic          free_we;

    logic [KEY_W-1:0] in_key, in_anc;
    logic [KW-1:0]    target;
    logic             hit, miss;
    logic [LW-1:0]    q_n;
    logic [LW-1:0]    alloc_s;

    assign in_key = s_tdata[33:2];
    assign in_anc = s_tdata[65:34];
    assign target = anc_phase_reg ? a_reg : k_reg;
    assign hit    = cmp_vld_reg && vld_rd_reg && (key_rd_reg == target);
    assign miss   = cmp_vld_reg && !hit && (cmp_idx_reg == LAST);
    assign q_n    = (node_reg == HEAD) ? head_next_reg : next_rd_reg;
    assign alloc_s = (rc_reg != '0) ? LW'(free_rd_reg) : LW'(fr_reg);
    assign key_raddr = (state_reg == S_SCAN) ? scan_reg[SW-1:0] : q_n[SW-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_end_reg, KEY_W'(out_nk_reg), out_st_reg};

    always_ff @(posedge clk)
    begin
        key_rd_reg  <= key_mem[key_raddr];
        vld_rd_reg  <= vld_reg[key_raddr];
        next_rd_reg <= next_mem[node_reg[SW-1:0]];
        prev_rd_reg <= prev_mem[node_reg[SW-1:0]];
        free_rd_reg <= free_mem[SW'(rc_reg - 1'b1)];
        if (key_we)
        begin
            key_mem[key_waddr] <= k_reg;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (free_we)
        begin
            free_mem[rc_reg[SW-1:0]] <= slot_reg[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (vld_we)
        begin
            vld_reg[key_waddr] <= vld_wdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        anc_phase_next = anc_phase_reg;
        scan_next      = scan_reg;
        cmp_idx_next   = scan_reg;
        cmp_vld_next   = 1'b0;
        node_next      = node_reg;
        slot_next      = slot_reg;
        after_next     = after_reg;
        head_next_next = head_next_reg;
        tail_prev_next = tail_prev_reg;
        rc_next        = rc_reg;
        fr_next        = fr_reg;
        res_st_next    = res_st_reg;
        res_nk_next    = res_nk_reg;
        res_end_next   = res_end_reg;
        key_we     = 1'b0;
        key_waddr  = slot_reg[SW-1:0];
        vld_we     = 1'b0;
        vld_wdata  = 1'b0;
        next_we    = 1'b0;
        next_waddr = slot_reg[SW-1:0];
        next_wdata = after_reg;
        prev_we    = 1'b0;
        prev_waddr = slot_reg[SW-1:0];
        prev_wdata = node_reg;
        free_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next       = s_tdata[1:0];
                    k_next         = in_key[KW-1:0];
                    a_next         = in_anc[KW-1:0];
                    anc_phase_next = 1'b0;
                    scan_next      = '0;
                    res_st_next    = ST_OK;
                    res_nk_next    = '0;
                    res_end_next   = 1'b0;
                    case (s_tdata[1:0])
                        CMD_INSERT, CMD_REMOVE:
                        begin
                            if (in_key[KW-1:0] == '0)
                            begin
                                res_st_next = ST_ABSENT;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (in_key[KW-1:0] == '0)
                            begin
                                node_next  = HEAD;
                                state_next = S_QRD;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_reg != CNT_FULL)
                begin
                    scan_next    = scan_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                if (hit)
                begin
                    cmp_vld_next = 1'b0;
                    node_next    = LW'(cmp_idx_reg);
                    slot_next    = LW'(cmp_idx_reg);
                    if (anc_phase_reg)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_INSERT:
                            begin
                                res_st_next = ST_DUP;
                                state_next  = S_DONE;
                            end
                            CMD_REMOVE: state_next = S_RMRD;
                            default:    state_next = S_QRD;
                        endcase
                    end
                end
                else if (miss)
                begin
                    cmp_vld_next = 1'b0;
                    if (cmd_reg == CMD_INSERT && !anc_phase_reg)
                    begin
                        if (a_reg == '0)
                        begin
                            node_next  = HEAD;
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            anc_phase_next = 1'b1;
                            scan_next      = '0;
                        end
                    end
                    else
                    begin
                        res_st_next = ST_ABSENT;
                        state_next  = S_DONE;
                    end
                end
            end
            S_ALLOC:
            begin
                if (rc_reg == '0 && fr_reg == CNT_FULL)
                begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_LINK1;
                end
            end
            S_LINK1:
            begin
                after_next = q_n;
                slot_next  = alloc_s;
                if (rc_reg != '0)
                begin
                    rc_next = rc_reg - 1'b1;
                end
                else
                begin
                    fr_next = fr_reg + 1'b1;
                end
                key_we     = 1'b1;
                key_waddr  = alloc_s[SW-1:0];
                vld_we     = 1'b1;
                vld_wdata  = 1'b1;
                next_we    = 1'b1;
                next_waddr = alloc_s[SW-1:0];
                next_wdata = q_n;
                prev_we    = 1'b1;
                prev_waddr = alloc_s[SW-1:0];
                prev_wdata = node_reg;
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                if (after_reg == TAIL)
                begin
                    tail_prev_next = slot_reg;
                end
                else
                begin
                    prev_we    = 1'b1;
                    prev_waddr = after_reg[SW-1:0];
                    prev_wdata = slot_reg;
                end
                if (node_reg == HEAD)
                begin
                    head_next_next = slot_reg;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = node_reg[SW-1:0];
                    next_wdata = slot_reg;
                end
                state_next = S_DONE;
            end
            S_RMRD:
            begin
                state_next = S_RMWR;
            end
            S_RMWR:
            begin
                if (prev_rd_reg == HEAD)
                begin
                    head_next_next = next_rd_reg;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd_reg[SW-1:0];
                    next_wdata = next_rd_reg;
                end
                if (next_rd_reg == TAIL)
                begin
                    tail_prev_next = prev_rd_reg;
                end
                else
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd_reg[SW-1:0];
                    prev_wdata = prev_rd_reg;
                end
                vld_we     = 1'b1;
                vld_wdata  = 1'b0;
                key_waddr  = slot_reg[SW-1:0];
                free_we    = 1'b1;
                rc_next    = rc_reg + 1'b1;
                state_next = S_DONE;
            end
            S_QRD:
            begin
                state_next = S_QNX;
            end
            S_QNX:
            begin
                if (q_n >= HEAD)
                begin
                    res_end_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_QKEY;
                end
            end
            S_QKEY:
            begin
                res_nk_next = key_rd_reg;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_vld_reg   <= 1'b0;
            head_next_reg <= TAIL;
            tail_prev_reg <= HEAD;
            rc_reg        <= '0;
            fr_reg        <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            head_next_reg <= head_next_next;
            tail_prev_reg <= tail_prev_next;
            rc_reg        <= rc_next;
            fr_reg        <= fr_next;
            if (state_reg == S_DONE && (!out_vld_reg || m_tready))
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        k_reg         <= k_next;
        a_reg         <= a_next;
        anc_phase_reg <= anc_phase_next;
        scan_reg      <= scan_next;
        cmp_idx_reg   <= cmp_idx_next;
        node_reg      <= node_next;
        slot_reg      <= slot_next;
        after_reg     <= after_next;
        res_st_reg    <= res_st_next;
        res_nk_reg    <= res_nk_next;
        res_end_reg   <= res_end_next;
        if (state_reg == S_DONE && (!out_vld_reg || m_tready))
        begin
            out_st_reg  <= res_st_reg;
            out_nk_reg  <= res_nk_reg;
            out_end_reg <= res_end_reg;
        end
    end
endmodule

>>> test/keyed_doubly_linked_list_tb.sv
// Testbench for the keyed doubly linked list: directed and random list commands checked against a predictor.
`timescale 1ns / 100ps
module keyed_doubly_linked_list_tb;
    import kdll_pkg::*;

    localparam int SLOTS = 256;
    localparam int HEAD = SLOTS;
    localparam int TAIL = SLOTS + 1;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic            at_end;
        logic [KEY_W-1:0] next_key;
        status_t         status;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    logic [KEY_W-1:0] slot_key [SLOTS];
    bit slot_used [SLOTS];
    int fwd [SLOTS+2];
    int back [SLOTS+2];
    int free_stack [SLOTS];
    int free_top;

    answer_t pending_answers[$];
    logic [KEY_W-1:0] live_keys[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit busy_sender = 1'b1;
    bit no_idle = 1'b0;
    bit hold_off = 1'b0;

    keyed_doubly_linked_list dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 clk = ~clk;

    function automatic int lookup_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void clear_list();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            free_stack[i] = SLOTS - 1 - i;
        end
        fwd[HEAD] = TAIL;
        back[TAIL] = HEAD;
        free_top = SLOTS;
        live_keys.delete();
    endfunction

    function automatic answer_t apply_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                              logic [KEY_W-1:0] a);
        answer_t r;
        int s, anc, after, p, n;
        r = '0;
        if (cmd == CMD_INSERT)
        begin
            anc = HEAD;
            if (a != 0)
                anc = lookup_slot(a);
            if (k == 0)
                r.status = ST_ABSENT;
            else if (lookup_slot(k) >= 0)
                r.status = ST_DUP;
            else if (anc < 0)
                r.status = ST_ABSENT;
            else if (free_top == 0)
                r.status = ST_FULL;
            else
            begin
                free_top--;
                s = free_stack[free_top];
                after = fwd[anc];
                slot_key[s] = k;
                slot_used[s] = 1'b1;
                fwd[s] = after;
                back[s] = anc;
                back[after] = s;
                fwd[anc] = s;
                live_keys = {live_keys, k};
            end
        end
        else if (cmd == CMD_REMOVE)
        begin
            s = (k == 0) ? -1 : lookup_slot(k);
            if (s < 0)
                r.status = ST_ABSENT;
            else
            begin
                p = back[s];
                n = fwd[s];
                fwd[p] = n;
                back[n] = p;
                slot_used[s] = 1'b0;
                if (free_top < SLOTS)
                begin
                    free_stack[free_top] = s;
                    free_top++;
                end
                foreach (live_keys[i])
                    if (live_keys[i] == k)
                    begin
                        live_keys.delete(i);
                        break;
                    end
            end
        end
        else if (cmd == CMD_QUERY)
        begin
            s = (k == 0) ? HEAD : lookup_slot(k);
            if (s < 0)
                r.status = ST_ABSENT;
            else
            begin
                n = fwd[s];
                if (n >= SLOTS)
                    r.at_end = 1'b1;
                else
                    r.next_key = slot_key[n];
            end
        end
        return r;
    endfunction

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k, logic [KEY_W-1:0] a);
        while (busy_sender && !no_idle && $urandom_range(99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata <= IN_W'({a, k, cmd});
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_answers = {pending_answers, apply_request(cmd, k, a)};
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_live();
        if (live_keys.size() == 0)
            return $urandom_range(1, 40);
        return live_keys[$urandom_range(live_keys.size() - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'd0;
            2, 3: return pick_live();
            default: return $urandom_range(1, 600);
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic test_directed();
        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_INSERT, 0, 0);
        send_request(CMD_REMOVE, 0, 0);
        send_request(CMD_REMOVE, 32'd5, 0);
        send_request(CMD_QUERY, 32'd5, 0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 0);
        send_request(CMD_INSERT, 32'd1, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'd2, 32'd77);
        send_request(CMD_INSERT, 32'hAAAA_5555, 32'd1);
        send_request(CMD_INSERT, 32'd1, 0);
        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_QUERY, 32'hFFFF_FFFF, 0);
        send_request(CMD_QUERY, 32'hAAAA_5555, 0);
        send_request(CMD_QUERY, 32'd1, 0);
        send_request(CMD_SPARE, 32'h5555_AAAA, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 0);
        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 0);
    endtask

    task automatic test_fill_store();
        for (int i = 0; i < SLOTS + 4; i++)
            send_request(CMD_INSERT, 32'h1000 + i, (i % 3 == 0) ? 32'd0 : pick_live());
        for (int i = 0; i < 12; i++)
            send_request(CMD_QUERY, pick_live(), 0);
        for (int i = 0; i < SLOTS; i++)
            send_request(CMD_REMOVE, pick_live(), 0);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        no_idle = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_request(CMD_INSERT, 32'h7000 + i, 0);
        join
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < 1400; i++)
        begin
            no_idle = (i >= 600 && i < 800);
            cmd = ($urandom_range(99) < 2) ? CMD_SPARE : CMD_W'($urandom_range(2));
            if (cmd == CMD_INSERT && $urandom_range(3) == 0)
                send_request(cmd, $urandom_range(1, 600), pick_live());
            else
                send_request(cmd, pick_key(), ($urandom_range(3) == 0) ? $urandom() : pick_key());
        end
        no_idle = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle || ($urandom_range(99) >= 38);
    end

    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = answer_t'(m_tdata[34:0]);
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.status !== want.status || got.next_key !== want.next_key ||
                    got.at_end !== want.at_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st=%0d nk=%h end=%0d, got st=%0d nk=%h end=%0d",
                                 want.status, want.next_key, want.at_end,
                                 got.status, got.next_key, got.at_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_list();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        test_directed();
        test_fill_store();
        test_backpressure();
        test_random();
        wait_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> filelist.f
rtl/kdll_pkg.sv
rtl/keyed_doubly_linked_list.sv
test/keyed_doubly_linked_list_tb.sv
